[rtl/tdpt_pkg.sv]
// Shared constants for the trial-division prime tester and its checker.
package tdpt_pkg;

    // Width of the tested number (supported range 4 to 64).
    localparam int VALUE_BITS = 32;

    // Trial candidates never pass about sqrt(2^VALUE_BITS) + 8.
    localparam int CAND_BITS = VALUE_BITS / 2 + 3;

    // Bit counter of the serial divider.
    localparam int COUNT_BITS = $clog2(VALUE_BITS);

    // Width used to compare a candidate with a quotient.
    localparam int CMP_BITS = VALUE_BITS + CAND_BITS;

endpackage

[rtl/trial_division_prime_test.sv]
// Trial-division prime tester: 6k-1 / 6k+1 candidates over a bit-serial divider.
// 0..5 and even values are answered from idle, with done in the cycle after start; otherwise one trial
//   division follows another (divisor 3, then 5, 7, 11, 13, ...) until a factor or the square bound is found.
// Throughput: one number at a time; start is taken only while busy is low.
// The restoring divider retires one quotient bit per cycle; it sets the pace.
// Reset: rst_n is asynchronous, active low; it returns the block to idle with done low.
// done is a one-cycle strobe with is_prime valid alongside; the receiver cannot stall.
module trial_division_prime_test
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [tdpt_pkg::VALUE_BITS-1:0] value,
    output logic                            done,
    output logic                            is_prime
);

    localparam int VB = tdpt_pkg::VALUE_BITS;
    localparam int CB = tdpt_pkg::CAND_BITS;
    localparam int NB = tdpt_pkg::COUNT_BITS;
    localparam int MB = tdpt_pkg::CMP_BITS;
    localparam logic [NB-1:0] LAST_BIT = NB'(VB - 1);

    // Control flow: idle, shift-subtract loop, evaluate a finished division.
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EVAL
    } state_t;

    // Which divisor the current division uses.
    typedef enum logic [1:0] {
        PH_THREE,   // divisor 3
        PH_LOW,     // divisor 6k-1, also checks the square bound
        PH_HIGH     // divisor 6k+1
    } phase_t;

    state_t          state_reg,    state_next;
    phase_t          phase_reg,    phase_next;
    logic [VB-1:0]   value_reg,    value_next;     // number under test
    logic [VB-1:0]   work_reg,     work_next;      // dividend bits out, quotient bits in
    logic [CB-1:0]   rem_reg,      rem_next;       // partial remainder
    logic [CB-1:0]   divisor_reg,  divisor_next;
    logic [CB-1:0]   cand_reg,     cand_next;      // current 6k-1 candidate
    logic [NB-1:0]   count_reg,    count_next;
    logic            done_reg,     done_next;
    logic            is_prime_reg, is_prime_next;

    // One restoring-division step.
    logic [CB:0]     rem_shift;
    logic [CB:0]     rem_diff;
    logic            rem_ge;

    // Evaluation terms.
    logic            rem_zero;
    logic            past_bound;      // candidate > value / candidate
    logic            small_prime;
    logic            trivial_comp;
    logic [CB-1:0]   cand_up;

    assign rem_shift    = {rem_reg, work_reg[VB-1]};
    assign rem_ge       = rem_shift >= {1'b0, divisor_reg};
    assign rem_diff     = rem_shift - {1'b0, divisor_reg};
    assign rem_zero     = (rem_reg == '0);
    assign past_bound   = MB'(cand_reg) > MB'(work_reg);
    assign cand_up      = cand_reg + CB'(6);

    assign small_prime  = value inside {VB'(2), VB'(3), VB'(5)};
    assign trivial_comp = (value < VB'(2)) || !value[0];

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        value_next    = value_reg;
        work_next     = work_reg;
        rem_next      = rem_reg;
        divisor_next  = divisor_reg;
        cand_next     = cand_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        is_prime_next = is_prime_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (small_prime)
                    begin
                        done_next     = 1'b1;
                        is_prime_next = 1'b1;
                    end
                    else if (trivial_comp)
                    begin
                        done_next     = 1'b1;
                        is_prime_next = 1'b0;
                    end
                    else
                    begin
                        // Odd and above 5: first rule out multiples of 3.
                        value_next   = value;
                        work_next    = value;
                        rem_next     = '0;
                        count_next   = '0;
                        divisor_next = CB'(3);
                        phase_next   = PH_THREE;
                        state_next   = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                work_next  = {work_reg[VB-2:0], rem_ge};
                rem_next   = rem_ge ? rem_diff[CB-1:0] : rem_shift[CB-1:0];
                count_next = count_reg + NB'(1);
                if (count_reg == LAST_BIT)
                begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                // work_reg holds the quotient, rem_reg the remainder.
                // Unless finished, launch the next division.
                work_next  = value_reg;
                rem_next   = '0;
                count_next = '0;
                state_next = S_DIV;
                case (phase_reg)
                    PH_THREE:
                    begin
                        if (rem_zero)
                        begin
                            done_next     = 1'b1;
                            is_prime_next = 1'b0;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            cand_next    = CB'(5);
                            divisor_next = CB'(5);
                            phase_next   = PH_LOW;
                        end
                    end
                    PH_LOW:
                    begin
                        if (past_bound)
                        begin
                            done_next     = 1'b1;
                            is_prime_next = 1'b1;
                            state_next    = S_IDLE;
                        end
                        else if (rem_zero)
                        begin
                            done_next     = 1'b1;
                            is_prime_next = 1'b0;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            divisor_next = cand_reg + CB'(2);
                            phase_next   = PH_HIGH;
                        end
                    end
                    PH_HIGH:
                    begin
                        if (rem_zero)
                        begin
                            done_next     = 1'b1;
                            is_prime_next = 1'b0;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            cand_next    = cand_up;
                            divisor_next = cand_up;
                            phase_next   = PH_LOW;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_THREE;
            value_reg    <= '0;
            work_reg     <= '0;
            rem_reg      <= '0;
            divisor_reg  <= '0;
            cand_reg     <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            is_prime_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            value_reg    <= value_next;
            work_reg     <= work_next;
            rem_reg      <= rem_next;
            divisor_reg  <= divisor_next;
            cand_reg     <= cand_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            is_prime_reg <= is_prime_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign is_prime = is_prime_reg;

endmodule

[rtl/tdpt_checker.sv]
// Port-level checks for the prime tester, bound to the top level.
module tdpt_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [tdpt_pkg::VALUE_BITS-1:0] value,
    input logic                            done,
    input logic                            is_prime
);

    localparam int VB = tdpt_pkg::VALUE_BITS;

    // A result only appears once the work is over.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_small_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (value == VB'(2) || value == VB'(3) || value == VB'(5)))
        |=> (done && is_prime))
        else $error("2, 3 or 5 not reported prime at once");

    a_even: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !value[0] && value != VB'(2))
        |=> (done && !is_prime))
        else $error("even value not rejected at once");

    a_odd_work: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && value[0] && value > VB'(5))
        |=> (busy && !done))
        else $error("odd value above 5 did not start trial division");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (.*);
